>>> sv/dbcw_pkg.sv
package dbcw_pkg;

   localparam int REQ_DATA_W = 240;
   localparam int RSP_DATA_W = 72;
   localparam int OP_W       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_NUM_W  = 54;
   localparam int DIV_DEN_W  = 16;

   localparam logic [2:0] OP_ACK      = 3'd0;
   localparam logic [2:0] OP_ECN      = 3'd1;
   localparam logic [2:0] OP_LOSS     = 3'd2;
   localparam logic [2:0] OP_TIMEOUT  = 3'd3;
   localparam logic [2:0] OP_SPURIOUS = 3'd4;
   localparam logic [2:0] OP_RTT      = 3'd5;
   localparam logic [2:0] OP_BLOCKED  = 3'd6;
   localparam logic [2:0] OP_RESET    = 3'd7;

   localparam logic [1:0] MODE_INIT   = 2'd0;
   localparam logic [1:0] MODE_EVAL   = 2'd1;
   localparam logic [1:0] MODE_FREEZE = 2'd2;

   localparam logic [2:0] REG_INITIAL_WINDOW = 3'd0;
   localparam logic [2:0] REG_MINIMUM_WINDOW = 3'd1;
   localparam logic [2:0] REG_DELAY_CAP      = 3'd2;
   localparam logic [2:0] REG_EPOCH_LENGTH   = 3'd3;
   localparam logic [2:0] REG_REPEAT_LIMIT   = 3'd4;

   localparam logic [31:0] DEF_INITIAL_WINDOW = 32'd15360;
   localparam logic [31:0] DEF_MINIMUM_WINDOW = 32'd3072;
   localparam logic [15:0] DEF_DELAY_CAP      = 16'd25000;
   localparam logic [23:0] DEF_EPOCH_LENGTH   = 24'd1000000;
   localparam logic [7:0]  DEF_REPEAT_LIMIT   = 8'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FREEZE,
      ST_OP,
      ST_ROLL_STEP,
      ST_ROLL_END,
      ST_RTT_EVAL,
      ST_RTT_DECIDE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_GROW,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_FREEZE_EXIT,
      CMD_OP,
      CMD_ROLL_INIT,
      CMD_ROLL_STEP,
      CMD_ROLL_END,
      CMD_RTT_EVAL,
      CMD_RTT_DECIDE,
      CMD_MUL,
      CMD_DIV_START,
      CMD_GROW,
      CMD_RESULT
   } cmd_type;

   typedef struct packed {
      logic is_rtt;
      logic roll_needed;
      logic roll_last;
      logic frozen;
      logic low_delay;
      logic init_mode;
      logic div_done;
   } status_type;

endpackage

>>> sv/dbcw_div.sv
module dbcw_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dbcw_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [dbcw_pkg::DIV_DEN_W-1:0] divisor,
   output logic                           done,
   output logic [dbcw_pkg::DIV_NUM_W-1:0] quotient
);
   import dbcw_pkg::*;

   localparam int STEPS = DIV_NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // two restoring steps per cycle; dividend shifts out as quotient shifts in
   always_comb begin
      logic [DIV_DEN_W:0]   r;
      logic [DIV_NUM_W-1:0] q;
      r       = rem_ff;
      q       = quo_ff;
      for (int k = 0; k < 2; k++) begin
         r = {r[DIV_DEN_W-1:0], q[DIV_NUM_W-1]};
         q = {q[DIV_NUM_W-2:0], 1'b0};
         if (r >= {1'b0, den_ff}) begin
            r    = r - {1'b0, den_ff};
            q[0] = 1'b1;
         end
      end
      rem_in  = r;
      quo_in  = q;
      cnt_in  = cnt_ff - 1'b1;
      busy_in = busy_ff && (cnt_ff != CNT_W'(1));
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(STEPS);
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/dbcw_datapath.sv
module dbcw_datapath #(
   parameter int HISTORY_DEPTH = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dbcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbcw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [dbcw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [dbcw_pkg::OP_W-1:0]       req_tuser,
   input  dbcw_pkg::cmd_type               cmd,
   output dbcw_pkg::status_type            status,
   output logic [dbcw_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dbcw_pkg::*;

   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   function automatic logic [15:0] delay_limit(input logic [31:0] r, input logic [15:0] cap);
      logic [28:0] d;
      d = r[31:3];
      return (d > {13'b0, cap}) ? cap : d[15:0];
   endfunction

   // configuration
   logic [31:0] cfg_iw_ff, cfg_mw_ff;
   logic [15:0] cfg_cap_ff;
   logic [23:0] cfg_el_ff;
   logic [7:0]  cfg_rl_ff;

   // latched item
   logic [2:0]  op_ff;
   logic [31:0] rtt_ff, fmax_ff;
   logic [23:0] bytes_ff;
   logic [47:0] now_ff, send_ff, acked_ff;
   logic        lc_ff, fr_ff, ga_ff;

   // controller state
   logic [31:0] window_ff, window_in;
   logic [1:0]  mode_ff, mode_in;
   logic [47:0] fend_ff, fend_in, eend_ff, eend_in, rseq_ff, rseq_in;
   logic [31:0] min_ff, min_in, roll_ff, roll_in;
   logic [15:0] thr_ff, thr_in;
   logic [31:0] hist_ff [HISTORY_DEPTH];
   logic [31:0] hist_in [HISTORY_DEPTH];
   logic [39:0] bsr_ff, bsr_in;
   logic [7:0]  ec_ff, ec_in;
   logic        fbt_ff, fbt_in, fnd_ff, fnd_in, trust_ff, trust_in;

   // work registers
   logic [31:0]      delta_ff, delta_in, minacc_ff, minacc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [55:0]      prod_ff;
   logic [RSP_DATA_W-1:0] out_ff;

   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_q;

   // congestion cut
   logic        cg_delay, cg_timeout, cg_skip;
   logic [31:0] cg_cut, cg_win;
   logic        low_delay;

   assign low_delay  = delta_ff < {16'b0, thr_ff};
   assign cg_delay   = (cmd == CMD_RTT_DECIDE);
   assign cg_timeout = (cmd == CMD_OP) && (op_ff == OP_TIMEOUT);
   assign cg_skip    = (mode_ff == MODE_FREEZE) && (!cg_timeout || !fbt_ff) &&
                       (!cg_delay || !fnd_ff);
   assign cg_cut     = cg_delay ? (window_ff - {3'b0, window_ff[31:3]}) : {1'b0, window_ff[31:1]};
   assign cg_win     = (cg_timeout || cg_cut < cfg_mw_ff) ? cfg_mw_ff : cg_cut;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_iw_ff  <= DEF_INITIAL_WINDOW;
         cfg_mw_ff  <= DEF_MINIMUM_WINDOW;
         cfg_cap_ff <= DEF_DELAY_CAP;
         cfg_el_ff  <= DEF_EPOCH_LENGTH;
         cfg_rl_ff  <= DEF_REPEAT_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_INITIAL_WINDOW: cfg_iw_ff  <= csr_wdata;
            REG_MINIMUM_WINDOW: cfg_mw_ff  <= csr_wdata;
            REG_DELAY_CAP:      cfg_cap_ff <= csr_wdata[15:0];
            REG_EPOCH_LENGTH:   cfg_el_ff  <= csr_wdata[23:0];
            REG_REPEAT_LIMIT:   cfg_rl_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         op_ff    <= req_tuser;
         rtt_ff   <= req_tdata[31:0];
         bytes_ff <= req_tdata[55:32];
         now_ff   <= req_tdata[103:56];
         lc_ff    <= req_tdata[104];
         fmax_ff  <= req_tdata[136:105];
         fr_ff    <= req_tdata[137];
         send_ff  <= req_tdata[185:138];
         acked_ff <= req_tdata[233:186];
         ga_ff    <= req_tdata[234];
      end
      if (cmd == CMD_MUL) prod_ff <= bsr_ff * (thr_ff - delta_ff[15:0]);
      if (cmd == CMD_RESULT) out_ff <= {6'b0, roll_ff, mode_ff, window_ff};
   end

   always_comb begin
      logic [40:0] ack_sum;
      logic [7:0]  ec_inc;
      logic [53:0] grow_add;
      logic [54:0] grow_sum;
      logic [31:0] hv;
      logic        do_cong, do_grow;

      window_in = window_ff; mode_in = mode_ff; fend_in = fend_ff; eend_in = eend_ff;
      rseq_in = rseq_ff; min_in = min_ff; roll_in = roll_ff; thr_in = thr_ff;
      hist_in = hist_ff; bsr_in = bsr_ff; ec_in = ec_ff; fbt_in = fbt_ff;
      fnd_in = fnd_ff; trust_in = trust_ff; delta_in = delta_ff;
      minacc_in = minacc_ff; idx_in = idx_ff;
      do_cong  = 1'b0;
      do_grow  = 1'b0;
      ack_sum  = {1'b0, bsr_ff} + {17'b0, bytes_ff};
      ec_inc   = (ec_ff == 8'hFF) ? ec_ff : ec_ff + 8'd1;
      grow_add = (cmd == CMD_GROW) ? div_q : {14'b0, bsr_ff};
      grow_sum = {23'b0, window_ff} + {1'b0, grow_add};
      hv       = hist_ff[idx_ff - 1'b1];

      unique case (cmd)
         CMD_FREEZE_EXIT: begin
            if (mode_ff == MODE_FREEZE && (now_ff > fend_ff || rseq_ff <= acked_ff)) begin
               mode_in = fbt_ff ? MODE_INIT : MODE_EVAL;
               fnd_in  = 1'b0;
               fbt_in  = 1'b0;
               ec_in   = '0;
               bsr_in  = '0;
            end
         end
         CMD_OP: begin
            case (op_ff) inside
               OP_ACK: begin
                  if (mode_ff != MODE_FREEZE)
                     bsr_in = ack_sum[40] ? {40{1'b1}} : ack_sum[39:0];
               end
               OP_ECN: do_cong = !cg_skip;
               OP_LOSS, OP_TIMEOUT: do_cong = lc_ff && !cg_skip;
               OP_SPURIOUS: begin
                  if (ec_ff != 8'd0) ec_in = ec_ff - 8'd1;
               end
               OP_RTT: begin
                  if (fr_ff && (fmax_ff < roll_ff || roll_ff == 32'd0)) begin
                     roll_in = fmax_ff;
                     if (fmax_ff < min_ff) min_in = fmax_ff;
                  end
               end
               OP_RESET: begin
                  window_in = cfg_iw_ff;
                  mode_in   = MODE_INIT;
                  fend_in   = '0;
                  rseq_in   = '0;
                  min_in    = rtt_ff;
                  roll_in   = rtt_ff;
                  thr_in    = delay_limit(rtt_ff, cfg_cap_ff);
                  for (int i = 0; i < HISTORY_DEPTH; i++) hist_in[i] = '0;
                  bsr_in    = '0;
                  ec_in     = '0;
                  fbt_in    = 1'b0;
                  fnd_in    = 1'b0;
                  trust_in  = 1'b0;
                  eend_in   = now_ff + {24'b0, cfg_el_ff};
               end
               default: ;
            endcase
         end
         CMD_ROLL_INIT: begin
            minacc_in = {32{1'b1}};
            idx_in    = IDX_W'(HISTORY_DEPTH - 1);
         end
         CMD_ROLL_STEP: begin
            hist_in[idx_ff] = hv;
            if (hv != 32'd0 && hv < minacc_ff) minacc_in = hv;
            idx_in = idx_ff - 1'b1;
         end
         CMD_ROLL_END: begin
            min_in     = minacc_ff;
            thr_in     = delay_limit(minacc_ff, cfg_cap_ff);
            hist_in[0] = roll_ff;
            roll_in    = fmax_ff;
            eend_in    = now_ff + {24'b0, cfg_el_ff};
         end
         CMD_RTT_EVAL: begin
            if (mode_ff != MODE_FREEZE) begin
               delta_in = '0;
               if (rtt_ff < min_ff) thr_in = delay_limit(min_ff, cfg_cap_ff);
               else if (trust_ff) delta_in = rtt_ff - min_ff;
               else begin
                  min_in   = rtt_ff;
                  roll_in  = rtt_ff;
                  trust_in = 1'b1;
               end
            end
         end
         CMD_RTT_DECIDE: begin
            if (low_delay) begin
               ec_in = '0;
               if (mode_ff == MODE_INIT) begin
                  do_grow = 1'b1;
                  bsr_in  = '0;
               end
            end else begin
               ec_in   = ec_inc;
               do_cong = (ec_inc >= cfg_rl_ff);
            end
         end
         CMD_GROW: begin
            do_grow = 1'b1;
            bsr_in  = '0;
         end
         default: ;
      endcase

      if (do_grow && ga_ff)
         window_in = (grow_sum[54:32] != '0) ? {32{1'b1}} : grow_sum[31:0];
      if (do_cong) begin
         fnd_in    = !cg_delay;
         fbt_in    = cg_timeout;
         mode_in   = MODE_FREEZE;
         fend_in   = now_ff + {16'b0, min_ff};
         rseq_in   = send_ff;
         ec_in     = '0;
         window_in = cg_win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= DEF_INITIAL_WINDOW;
         mode_ff   <= MODE_INIT;
         fend_ff   <= '0;
         eend_ff   <= {24'b0, DEF_EPOCH_LENGTH};
         rseq_ff   <= '0;
         min_ff    <= '0;
         roll_ff   <= '0;
         thr_ff    <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
         bsr_ff    <= '0;
         ec_ff     <= '0;
         fbt_ff    <= 1'b0;
         fnd_ff    <= 1'b0;
         trust_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         mode_ff   <= mode_in;
         fend_ff   <= fend_in;
         eend_ff   <= eend_in;
         rseq_ff   <= rseq_in;
         min_ff    <= min_in;
         roll_ff   <= roll_in;
         thr_ff    <= thr_in;
         hist_ff   <= hist_in;
         bsr_ff    <= bsr_in;
         ec_ff     <= ec_in;
         fbt_ff    <= fbt_in;
         fnd_ff    <= fnd_in;
         trust_ff  <= trust_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff  <= delta_in;
      minacc_ff <= minacc_in;
      idx_ff    <= idx_in;
   end

   dbcw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd == CMD_DIV_START),
      .dividend (prod_ff[55:2]),
      .divisor  (thr_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.is_rtt      = (op_ff == OP_RTT);
   assign status.roll_needed = (op_ff == OP_RTT) && fr_ff && (now_ff > eend_ff);
   assign status.roll_last   = (idx_ff == IDX_W'(1));
   assign status.frozen      = (mode_ff == MODE_FREEZE);
   assign status.low_delay   = low_delay;
   assign status.init_mode   = (mode_ff == MODE_INIT);
   assign status.div_done    = div_done;
   assign rsp_tdata          = out_ff;

endmodule

>>> sv/dbcw_ctrl.sv
module dbcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  dbcw_pkg::status_type status,
   output dbcw_pkg::cmd_type    cmd
);
   import dbcw_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = CMD_NONE;
      req_tready = 1'b0;
      valid_in   = valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = CMD_LOAD;
               state_in = ST_FREEZE;
            end
         end
         ST_FREEZE: begin
            cmd      = CMD_FREEZE_EXIT;
            state_in = ST_OP;
         end
         ST_OP: begin
            if (status.roll_needed) begin
               cmd      = CMD_ROLL_INIT;
               state_in = ST_ROLL_STEP;
            end else begin
               cmd      = CMD_OP;
               state_in = status.is_rtt ? ST_RTT_EVAL : ST_DONE;
            end
         end
         ST_ROLL_STEP: begin
            cmd = CMD_ROLL_STEP;
            if (status.roll_last) state_in = ST_ROLL_END;
         end
         ST_ROLL_END: begin
            cmd      = CMD_ROLL_END;
            state_in = ST_RTT_EVAL;
         end
         ST_RTT_EVAL: begin
            cmd      = CMD_RTT_EVAL;
            state_in = status.frozen ? ST_DONE : ST_RTT_DECIDE;
         end
         ST_RTT_DECIDE: begin
            cmd      = CMD_RTT_DECIDE;
            state_in = (status.low_delay && !status.init_mode) ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd      = CMD_MUL;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd      = CMD_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_GROW;
         end
         ST_GROW: begin
            cmd      = CMD_GROW;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd      = CMD_RESULT;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = valid_ff;

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_FREEZE)
      else $error("accepted item did not start processing");
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT) |->
         ($past(state_ff) == ST_DIV_START || $past(state_ff) == ST_DIV_WAIT))
      else $error("divider wait entered without start");
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");
`endif

endmodule

>>> sv/delay_based_congestion_window.sv
// Processing: freeze-exit check, then the opcode step; an RTT sample adds an
// evaluation and, unless frozen, a decision; a low-delay sample in eval mode
// adds a multiply and a radix-4 divide; an epoch roll replaces the opcode step.
// Throughput: one item in flight; the next item is accepted the cycle after the
// result is registered, which waits while a previous result is not yet taken.
// Reset: synchronous, active high; config, controller state and FSM reset.
module delay_based_congestion_window #(
   parameter int HISTORY_DEPTH = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dbcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbcw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rtt_sample, bytes_acked, now_us, loss_confirmed, filtered_rtt_max,
   // filter_ready, send_sequence, acked_sequence, growth_allowed
   input  logic [dbcw_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [dbcw_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // window_bytes, mode, epoch_min_rtt
   output logic [dbcw_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dbcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   dbcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dbcw_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> bench/delay_based_congestion_window_tb.sv
`timescale 1ns / 100ps

module delay_based_congestion_window_tb;
   import dbcw_pkg::*;

   localparam int HIST = 6;
   localparam int STALL_LIMIT = 5000;
   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [2:0]  opcode;
      logic [31:0] rtt_sample;
      logic [23:0] bytes_acked;
      logic [47:0] now_us;
      logic        loss_confirmed;
      logic [31:0] filtered_rtt_max;
      logic        filter_ready;
      logic [47:0] send_sequence;
      logic [47:0] acked_sequence;
      logic        growth_allowed;
   } event_type;

   // packed from the top bit down: epoch_min_rtt, mode, window_bytes
   typedef struct packed {
      logic [31:0] epoch_min_rtt;
      logic [1:0]  mode;
      logic [31:0] window_bytes;
   } window_report_type;

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   delay_based_congestion_window dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // controller shadow: configuration
   logic [31:0] cfg_init_win, cfg_min_win;
   logic [15:0] cfg_cap;
   logic [23:0] cfg_epoch_len;
   logic [7:0]  cfg_repeat;
   // controller shadow: state
   logic [31:0] win;
   logic [1:0]  ctl_mode;
   logic [47:0] freeze_until, epoch_until, recover_seq;
   logic [31:0] min_rtt_us, roll_min_us;
   logic [15:0] delay_thresh;
   logic [31:0] epoch_mins [HIST];
   logic [63:0] pending_bytes;
   int          high_delay_run;
   logic        frozen_by_timeout, frozen_not_delay, min_valid;

   window_report_type expected_reports[$];
   int errors = 0;
   int accepted = 0;
   int op_seen [8];
   int tx_idle_pct = 0, rx_idle_pct = 0;
   int stall_cycles = 0;

   // traffic context for well-formed random events
   logic [47:0] now_ctr, snd_ctr, ack_ctr;
   logic [31:0] base_rtt;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] thresh_of(logic [31:0] rtt);
      logic [31:0] d;
      d = rtt >> 3;
      return (d > cfg_cap) ? cfg_cap : d[15:0];
   endfunction

   function automatic void restart(logic [47:0] now, logic [31:0] smoothed);
      win = cfg_init_win;
      ctl_mode = MODE_INIT;
      freeze_until = 0;
      recover_seq = 0;
      min_rtt_us = smoothed;
      roll_min_us = smoothed;
      delay_thresh = thresh_of(smoothed);
      for (int i = 0; i < HIST; i++) epoch_mins[i] = 0;
      pending_bytes = 0;
      high_delay_run = 0;
      frozen_by_timeout = 0;
      frozen_not_delay = 0;
      min_valid = 0;
      epoch_until = (now + cfg_epoch_len) & M48;
   endfunction

   function automatic void cut_window(logic [47:0] now, logic [47:0] sseq,
                                      bit by_delay, bit by_timeout);
      if (ctl_mode == MODE_FREEZE && (!by_timeout || !frozen_by_timeout) &&
          (!by_delay || !frozen_not_delay))
         return;
      frozen_not_delay = !by_delay;
      frozen_by_timeout = by_timeout;
      ctl_mode = MODE_FREEZE;
      freeze_until = (now + min_rtt_us) & M48;
      recover_seq = sseq;
      high_delay_run = 0;
      if (by_delay) win = win - (win >> 3);
      else win = win >> 1;
      if (by_timeout || win < cfg_min_win) win = cfg_min_win;
   endfunction

   function automatic void take_rtt(event_type e);
      logic [31:0] delta;
      logic [63:0] add, sum;
      delta = 0;
      if (e.filter_ready) begin
         if (e.now_us > epoch_until) begin
            min_rtt_us = 32'hFFFF_FFFF;
            for (int i = HIST - 1; i > 0; i--) begin
               epoch_mins[i] = epoch_mins[i-1];
               if (epoch_mins[i] > 0 && epoch_mins[i] < min_rtt_us)
                  min_rtt_us = epoch_mins[i];
            end
            delay_thresh = thresh_of(min_rtt_us);
            epoch_mins[0] = roll_min_us;
            roll_min_us = e.filtered_rtt_max;
            epoch_until = (e.now_us + cfg_epoch_len) & M48;
         end else if (e.filtered_rtt_max < roll_min_us || roll_min_us == 0) begin
            roll_min_us = e.filtered_rtt_max;
            if (roll_min_us < min_rtt_us) min_rtt_us = roll_min_us;
         end
      end
      if (ctl_mode == MODE_FREEZE) return;
      if (e.rtt_sample < min_rtt_us) delay_thresh = thresh_of(min_rtt_us);
      else if (min_valid) delta = e.rtt_sample - min_rtt_us;
      else begin
         min_rtt_us = e.rtt_sample;
         roll_min_us = e.rtt_sample;
         min_valid = 1;
      end
      if (delta < delay_thresh) begin
         high_delay_run = 0;
         if (ctl_mode == MODE_INIT) add = pending_bytes;
         else add = (pending_bytes * (delay_thresh - delta)) / (64'd4 * delay_thresh);
         if (e.growth_allowed) begin
            sum = win + add;
            win = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         end
         pending_bytes = 0;
      end else begin
         if (high_delay_run < 255) high_delay_run++;
         if (high_delay_run >= cfg_repeat) cut_window(e.now_us, e.send_sequence, 1, 0);
      end
   endfunction

   function automatic window_report_type predict_window(event_type e);
      window_report_type r;
      if (ctl_mode == MODE_FREEZE &&
          (e.now_us > freeze_until || recover_seq <= e.acked_sequence)) begin
         ctl_mode = frozen_by_timeout ? MODE_INIT : MODE_EVAL;
         frozen_not_delay = 0;
         frozen_by_timeout = 0;
         high_delay_run = 0;
         pending_bytes = 0;
      end
      case (e.opcode)
         OP_ACK: if (ctl_mode != MODE_FREEZE) begin
            pending_bytes += e.bytes_acked;
            if (pending_bytes > 64'hFF_FFFF_FFFF) pending_bytes = 64'hFF_FFFF_FFFF;
         end
         OP_ECN: cut_window(e.now_us, e.send_sequence, 0, 0);
         OP_LOSS, OP_TIMEOUT:
            if (e.loss_confirmed)
               cut_window(e.now_us, e.send_sequence, 0, e.opcode == OP_TIMEOUT);
         OP_SPURIOUS: if (high_delay_run > 0) high_delay_run--;
         OP_RTT: take_rtt(e);
         OP_RESET: restart(e.now_us, e.rtt_sample);
         default: ;
      endcase
      r.window_bytes = win;
      r.mode = ctl_mode;
      r.epoch_min_rtt = roll_min_us;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
      errors++;
      $display("MISMATCH item %0d %s: got %0h expected %0h", accepted, field, got, exp);
   endtask

   // result checker
   always @(posedge clock) begin
      window_report_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[65:0];
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected result window", got.window_bytes, 32'd0);
         end else begin
            exp = expected_reports.pop_front();
            if (got.window_bytes !== exp.window_bytes)
               report_mismatch("window_bytes", got.window_bytes, exp.window_bytes);
            if (got.mode !== exp.mode)
               report_mismatch("mode", {30'b0, got.mode}, {30'b0, exp.mode});
            if (got.epoch_min_rtt !== exp.epoch_min_rtt)
               report_mismatch("epoch_min_rtt", got.epoch_min_rtt, exp.epoch_min_rtt);
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_event(event_type e);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid = 0;
      end
      @(negedge clock);
      req_tvalid = 1;
      req_tuser = e.opcode;
      req_tdata = {5'b0, e.growth_allowed, e.acked_sequence, e.send_sequence,
                   e.filter_ready, e.filtered_rtt_max, e.loss_confirmed, e.now_us,
                   e.bytes_acked, e.rtt_sample};
      do @(posedge clock); while (!req_tready);
      expected_reports.push_back(predict_window(e));
      accepted++;
      op_seen[e.opcode]++;
   endtask

   // lower valid and wait until the block is idle
   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         REG_INITIAL_WINDOW: cfg_init_win = val;
         REG_MINIMUM_WINDOW: cfg_min_win = val;
         REG_DELAY_CAP: cfg_cap = val[15:0];
         REG_EPOCH_LENGTH: cfg_epoch_len = val[23:0];
         REG_REPEAT_LIMIT: cfg_repeat = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] iw, logic [31:0] mw, logic [15:0] cap,
                             logic [23:0] ep, logic [7:0] rep);
      drain();
      write_reg(REG_INITIAL_WINDOW, iw);
      write_reg(REG_MINIMUM_WINDOW, mw);
      write_reg(REG_DELAY_CAP, {16'b0, cap});
      write_reg(REG_EPOCH_LENGTH, {8'b0, ep});
      write_reg(REG_REPEAT_LIMIT, {24'b0, rep});
   endtask

   function automatic event_type blank_event(logic [2:0] op);
      event_type e;
      e = '{opcode: op, rtt_sample: base_rtt, bytes_acked: 24'd1460, now_us: now_ctr,
            loss_confirmed: 1, filtered_rtt_max: base_rtt, filter_ready: 1,
            send_sequence: snd_ctr, acked_sequence: ack_ctr, growth_allowed: 1};
      return e;
   endfunction

   // random event on a plausible connection timeline, sometimes pure noise
   function automatic event_type traffic_event();
      event_type e;
      int pick;
      pick = $urandom_range(99);
      now_ctr = now_ctr + 48'($urandom_range(3000));
      snd_ctr = snd_ctr + 48'($urandom_range(3));
      if ($urandom_range(3) == 0) ack_ctr = snd_ctr - 48'($urandom_range(2));
      e = blank_event(pick < 35 ? OP_ACK : pick < 70 ? OP_RTT : pick < 76 ? OP_ECN :
                      pick < 84 ? OP_LOSS : pick < 88 ? OP_TIMEOUT :
                      pick < 93 ? OP_SPURIOUS : pick < 97 ? OP_BLOCKED : OP_RESET);
      e.rtt_sample = base_rtt + $urandom_range(base_rtt / 4);
      if ($urandom_range(2) == 0) e.rtt_sample = base_rtt - $urandom_range(base_rtt / 16);
      e.filtered_rtt_max = base_rtt + $urandom_range(base_rtt / 8) - base_rtt / 16;
      e.bytes_acked = 24'($urandom_range(65535));
      e.loss_confirmed = $urandom_range(3) != 0;
      e.filter_ready = $urandom_range(4) != 0;
      e.growth_allowed = $urandom_range(5) != 0;
      if ($urandom_range(19) == 0) begin
         e.rtt_sample = $urandom;
         e.bytes_acked = 24'($urandom);
         e.now_us = 48'({$urandom, $urandom});
         e.filtered_rtt_max = $urandom;
         e.send_sequence = 48'({$urandom, $urandom});
         e.acked_sequence = 48'({$urandom, $urandom});
      end
      if ($urandom_range(199) == 0) base_rtt = $urandom_range(200000, 500);
      return e;
   endfunction

   task automatic test_directed();
      event_type e;
      e = blank_event(OP_RESET);
      send_event(e);
      for (int op = 0; op < 8; op++) send_event(blank_event(op[2:0]));
      // full-range fields
      e = blank_event(OP_ACK);
      e.bytes_acked = 24'hFF_FFFF;
      send_event(e);
      e = blank_event(OP_RTT);
      e.rtt_sample = 32'hFFFF_FFFF;
      e.filtered_rtt_max = 32'hFFFF_FFFF;
      e.now_us = M48;
      e.send_sequence = M48;
      e.acked_sequence = M48;
      send_event(e);
      // unconfirmed loss and timeout, spurious loss, blocked
      e = blank_event(OP_LOSS);
      e.loss_confirmed = 0;
      send_event(e);
      e.opcode = OP_TIMEOUT;
      send_event(e);
      send_event(blank_event(OP_SPURIOUS));
      send_event(blank_event(OP_BLOCKED));
      // empty history epoch roll, then a timeout freeze and its exit
      e = blank_event(OP_RESET);
      e.rtt_sample = 0;
      e.now_us = 0;
      send_event(e);
      e = blank_event(OP_RTT);
      e.now_us = 48'd2_000_000;
      send_event(e);
      e = blank_event(OP_TIMEOUT);
      e.send_sequence = M48;
      e.acked_sequence = 0;
      send_event(e);
      e = blank_event(OP_ACK);
      e.now_us = M48;
      e.acked_sequence = 0;
      send_event(e);
      // zero threshold: every sample is high delay
      e = blank_event(OP_RESET);
      e.rtt_sample = 7;
      send_event(e);
      repeat (5) send_event(blank_event(OP_RTT));
      e = blank_event(OP_ACK);
      e.growth_allowed = 0;
      send_event(e);
   endtask

   // grow with a saturating window and drive config registers to high and low extremes
   task automatic test_extremes();
      event_type e;
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 24'd1, 8'd1);
      write_reg(3'd5, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'h0);
      e = blank_event(OP_RESET);
      e.rtt_sample = 32'd80000;
      send_event(e);
      for (int i = 0; i < 6; i++) begin
         e = blank_event(OP_ACK);
         e.bytes_acked = 24'hFF_FFFF;
         send_event(e);
         e = blank_event(i[0] ? OP_RTT : OP_ECN);
         e.rtt_sample = 32'd80000;
         e.now_us = now_ctr + 48'(i * 5);
         send_event(e);
      end
      set_config(32'd0, 32'd0, 16'd0, 24'hFF_FFFF, 8'd255);
      send_event(blank_event(OP_RESET));
      repeat (4) send_event(blank_event(OP_ECN));
   endtask

   task automatic run_traffic(int count, bit hold_off);
      for (int i = 0; i < count; i++) begin
         if (hold_off && i % 50 == 25) drain();
         send_event(traffic_event());
      end
   endtask

   task automatic test_random_phases();
      set_config(32'd15360, 32'd3072, 16'd25000, 24'd1000000, 8'd4);
      tx_idle_pct = 0; rx_idle_pct = 0;
      run_traffic(250, 0);
      set_config(32'd30000, 32'd1500, 16'd3000, 24'd20000, 8'd2);
      tx_idle_pct = 83; rx_idle_pct = 0;
      run_traffic(250, 1);
      set_config(32'd100000, 32'd6000, 16'hFFFF, 24'd5000, 8'd8);
      tx_idle_pct = 0; rx_idle_pct = 83;
      run_traffic(250, 0);
      set_config(32'd8000, 32'd1000, 16'd500, 24'd1, 8'd1);
      tx_idle_pct = 16; rx_idle_pct = 16;
      run_traffic(250, 0);
   endtask

   initial begin
      reset = 1;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_tvalid = 0; req_tdata = 0; req_tuser = 0;
      cfg_init_win = DEF_INITIAL_WINDOW;
      cfg_min_win = DEF_MINIMUM_WINDOW;
      cfg_cap = DEF_DELAY_CAP;
      cfg_epoch_len = DEF_EPOCH_LENGTH;
      cfg_repeat = DEF_REPEAT_LIMIT;
      restart(48'd0, 32'd0);
      now_ctr = 48'd1000; snd_ctr = 48'd100; ack_ctr = 48'd90; base_rtt = 32'd20000;
      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_extremes();
      test_random_phases();
      drain();
      $display("Covered %0d events (ack %0d, rtt %0d, ecn %0d, loss %0d, timeout %0d)",
               accepted, op_seen[OP_ACK], op_seen[OP_RTT], op_seen[OP_ECN],
               op_seen[OP_LOSS], op_seen[OP_TIMEOUT]);
      $display("across 6 register settings and 4 flow-control phases, %0d mismatches",
               errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
